### hw/rtl/gcdb_pkg.sv
// Shared types, constants and helper functions for the great circle distance and bearing block.
package gcdb_pkg;

  localparam int unsigned ANGLE_ITERATIONS_DEF = 24;
  localparam int unsigned SC_LANES = 3;
  localparam int unsigned SQRT_STEPS = 31;
  localparam int unsigned DIV_STEPS = 30;

  typedef logic signed [31:0] q30_t;
  typedef logic [31:0] phase_t;
  typedef logic signed [33:0] cw_t;

  localparam cw_t ONE_Q30 = 34'sd1073741824;
  localparam cw_t HALF_S = 34'sd2147483648;
  localparam cw_t KINV_Q30 = 34'sd652032874;
  localparam q30_t ONE_Q30_32 = 32'sd1073741824;
  localparam phase_t HALF_TURN = 32'h8000_0000;
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
  localparam logic [23:0] RADIUS_RESET = 24'd6371000;
  localparam logic [32:0] RECIP_45 = 33'd6108397933;
  localparam logic [12:0] RECIP_45_S = 13'd5826;
  localparam logic [31:0] LON_BIAS = 32'd1509949440;
  localparam logic signed [63:0] SQ_ONE = 64'sh1000_0000_0000_0000;

  typedef struct packed {
    logic [34:0] rem;
    logic [30:0] root;
  } sq_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [29:0] quo;
  } dv_t;

  function automatic logic [31:0] atan_phase(input int unsigned i);
    logic [31:0] v;
    case (i)
      0: v = 32'd536870912;
      1: v = 32'd316933406;
      2: v = 32'd167458907;
      3: v = 32'd85004756;
      4: v = 32'd42667331;
      5: v = 32'd21354465;
      6: v = 32'd10679838;
      7: v = 32'd5340245;
      8: v = 32'd2670163;
      9: v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      28: v = 32'd3;
      29: v = 32'd1;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic cw_t rnd30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd536870912;
    return t[63:30];
  endfunction

  function automatic q30_t clamp_q30(input cw_t v);
    q30_t r;
    if (v > ONE_Q30) begin
      r = ONE_Q30_32;
    end else if (v < -ONE_Q30) begin
      r = -ONE_Q30_32;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic sq_t sqrt_step(input sq_t a, input logic [1:0] pair);
    logic [34:0] r2;
    logic [34:0] tr;
    sq_t o;
    r2 = {a.rem[32:0], pair};
    tr = {2'b00, a.root, 2'b01};
    if (r2 >= tr) begin
      o.rem = r2 - tr;
      o.root = {a.root[29:0], 1'b1};
    end else begin
      o.rem = r2;
      o.root = {a.root[29:0], 1'b0};
    end
    return o;
  endfunction

  function automatic dv_t div_step(input dv_t a, input logic [30:0] d);
    logic [31:0] r2;
    dv_t o;
    r2 = {a.rem[30:0], 1'b0};
    if (r2 >= {1'b0, d}) begin
      o.rem = r2 - {1'b0, d};
      o.quo = {a.quo[28:0], 1'b1};
    end else begin
      o.rem = r2;
      o.quo = {a.quo[28:0], 1'b0};
    end
    return o;
  endfunction

  function automatic int unsigned pipe_latency(input int unsigned iter);
    return 112 + 3 * iter;
  endfunction

endpackage

### hw/rtl/great_circle_distance_bearing.sv
// Great circle distance and initial bearing: top level pipeline.
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// The pipeline holds three CORDIC chains, two 31-stage square roots and a 30-stage divider.
// Results appear for one cycle with done and cannot be held off by the receiver.
// Reset clears all valid bits and sets the radius to 6371000 m.
module great_circle_distance_bearing
  import gcdb_pkg::*;
#(
  parameter int unsigned ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [29:0] start_lat,
  input  logic signed [30:0] start_lon,
  input  logic signed [29:0] end_lat,
  input  logic signed [30:0] end_lon,
  input  logic               cfg_we,
  input  logic [23:0]        cfg_wdata,
  output logic               done,
  output logic [29:0]        distance,
  output logic [23:0]        bearing,
  output logic               degenerate
);

  typedef struct packed {
    q30_t   c;
    q30_t   sla1;
    q30_t   sla2;
    q30_t   cla1;
    phase_t dl;
  } trig_t;

  typedef struct packed {
    logic [30:0] s;
    trig_t       t;
  } trig_s_t;

  typedef struct packed {
    logic [29:0] gc_dist;
    phase_t      dl;
    logic        degen;
    logic        sat;
    logic        neg;
  } bs_t;

  typedef struct packed {
    q30_t f;
    bs_t  b;
  } fs_t;

  logic [23:0] radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_we) begin
      radius <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  // phase conversion
  logic   ph_valid;
  phase_t ph_lat1, ph_lat2, ph_dlon;

  gcdb_phase u_phase (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .start_lat (start_lat),
    .start_lon (start_lon),
    .end_lat   (end_lat),
    .end_lon   (end_lon),
    .out_valid (ph_valid),
    .out_lat1  (ph_lat1),
    .out_lat2  (ph_lat2),
    .out_dlon  (ph_dlon)
  );

  // sine and cosine
  phase_t sc_phase [SC_LANES];
  q30_t   sc_cos [SC_LANES];
  q30_t   sc_sin [SC_LANES];
  phase_t sc_dl;
  logic   sc_valid;

  assign sc_phase[0] = ph_lat1;
  assign sc_phase[1] = ph_lat2;
  assign sc_phase[2] = ph_dlon;

  gcdb_sincos #(.ITER(ANGLE_ITERATIONS), .TW($bits(phase_t))) u_sincos (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ph_valid),
    .in_phase  (sc_phase),
    .in_side   (ph_dlon),
    .out_valid (sc_valid),
    .out_cos   (sc_cos),
    .out_sin   (sc_sin),
    .out_side  (sc_dl)
  );

  // cosine of the central angle
  logic signed [63:0] p_ss, p_cc, p_ccd, p_csq;
  logic   m1_v, m2_v, m3_v, q1_v;
  q30_t   m1_ss, m1_cc, m1_cdl, m2_ss, m2_ccd, m3_c;
  trig_t  m1_t, m2_t, m3_t, m3_tc, q1_t;
  logic [61:0] q1_n;

  assign p_ss  = sc_sin[0] * sc_sin[1];
  assign p_cc  = sc_cos[0] * sc_cos[1];
  assign p_ccd = m1_cc * m1_cdl;
  assign p_csq = m3_c * m3_c;

  always_comb begin
    m3_tc = m3_t;
    m3_tc.c = m3_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
      m2_v <= 1'b0;
      m3_v <= 1'b0;
      q1_v <= 1'b0;
    end else begin
      m1_v <= sc_valid;
      m2_v <= m1_v;
      m3_v <= m2_v;
      q1_v <= m3_v;
    end
    m1_ss     <= 32'(rnd30(p_ss));
    m1_cc     <= 32'(rnd30(p_cc));
    m1_cdl    <= sc_cos[2];
    m1_t.c    <= '0;
    m1_t.sla1 <= sc_sin[0];
    m1_t.sla2 <= sc_sin[1];
    m1_t.cla1 <= sc_cos[0];
    m1_t.dl   <= sc_dl;
    m2_ss     <= m1_ss;
    m2_ccd    <= 32'(rnd30(p_ccd));
    m2_t      <= m1_t;
    m3_c      <= clamp_q30(34'(m2_ss) + 34'(m2_ccd));
    m3_t      <= m2_t;
    q1_n      <= 62'(SQ_ONE - p_csq);
    q1_t      <= m3_tc;
  end

  // sine of the central angle
  logic        s1_valid;
  logic [30:0] s1_root;
  trig_t       s1_t;

  gcdb_isqrt #(.TW($bits(trig_t))) u_sqrt_sigma (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q1_v),
    .in_n      (q1_n),
    .in_side   (q1_t),
    .out_valid (s1_valid),
    .out_root  (s1_root),
    .out_side  (s1_t)
  );

  // central angle
  logic    a1_valid;
  phase_t  a1_sigma;
  trig_s_t a1_in_side, a1_side;

  assign a1_in_side.s = s1_root;
  assign a1_in_side.t = s1_t;

  gcdb_angle #(.ITER(ANGLE_ITERATIONS), .TW($bits(trig_s_t))) u_angle_sigma (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_x      (s1_t.c),
    .in_y      ($signed({1'b0, s1_root})),
    .in_side   (a1_in_side),
    .out_valid (a1_valid),
    .out_angle (a1_sigma),
    .out_side  (a1_side)
  );

  // distance and bearing quotient operands
  logic               d1_v, d2_v, d3_v;
  logic [55:0]        d1_t;
  logic [55:0]        d2_a;
  logic [31:0]        d2_b;
  logic [63:0]        d_bp;
  logic [56:0]        d_acc;
  logic [29:0]        d3_dist;
  logic signed [63:0] b1_pn, b1_pd;
  q30_t               b1_sla2;
  phase_t             b1_dl, b2_dl;
  cw_t                b2_num, b2_den, b_an, b_ad;
  logic [30:0]        b3_an, b3_ad;
  bs_t                b3_bs;

  assign d_bp  = d1_t[31:0] * TWO_PI_Q29;
  assign d_acc = 57'(d2_a) + 57'(d2_b) + 57'd16777216;
  assign b_an  = (b2_num < 0) ? -b2_num : b2_num;
  assign b_ad  = (b2_den < 0) ? -b2_den : b2_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_v <= 1'b0;
      d2_v <= 1'b0;
      d3_v <= 1'b0;
    end else begin
      d1_v <= a1_valid;
      d2_v <= d1_v;
      d3_v <= d2_v;
    end
    d1_t    <= a1_sigma * radius;
    b1_pn   <= a1_side.t.sla1 * a1_side.t.c;
    b1_pd   <= a1_side.t.cla1 * $signed({1'b0, a1_side.s});
    b1_sla2 <= a1_side.t.sla2;
    b1_dl   <= a1_side.t.dl;
    d2_a    <= d1_t[55:32] * TWO_PI_Q29;
    d2_b    <= d_bp[63:32];
    b2_num  <= 34'(b1_sla2) - rnd30(b1_pn);
    b2_den  <= rnd30(b1_pd);
    b2_dl   <= b1_dl;
    if (d_acc[56:25] > 32'h3FFF_FFFF) begin
      d3_dist <= 30'h3FFF_FFFF;
    end else begin
      d3_dist <= d_acc[54:25];
    end
    b3_an         <= b_an[30:0];
    b3_ad         <= b_ad[30:0];
    b3_bs.gc_dist <= '0;
    b3_bs.dl      <= b2_dl;
    b3_bs.degen   <= (b2_den == 0);
    b3_bs.sat     <= (b_an >= b_ad);
    b3_bs.neg     <= (b2_num[33] != b2_den[33]);
  end

  // quotient
  bs_t         dv_in_side, dv_side;
  logic        dv_valid;
  logic [29:0] dv_quo;

  always_comb begin
    dv_in_side = b3_bs;
    dv_in_side.gc_dist = d3_dist;
  end

  gcdb_div #(.TW($bits(bs_t))) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d3_v),
    .in_num    (b3_an),
    .in_den    (b3_ad),
    .in_side   (dv_in_side),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  logic               f1_v, f2_v;
  q30_t               f1_f, f_q;
  bs_t                f1_bs;
  fs_t                f2_s;
  logic [61:0]        f2_n;
  logic signed [63:0] p_fsq;

  assign f_q   = $signed({2'b00, dv_quo});
  assign p_fsq = f1_f * f1_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
    end else begin
      f1_v <= dv_valid;
      f2_v <= f1_v;
    end
    if (dv_side.sat) begin
      f1_f <= dv_side.neg ? -ONE_Q30_32 : ONE_Q30_32;
    end else begin
      f1_f <= dv_side.neg ? -f_q : f_q;
    end
    f1_bs  <= dv_side;
    f2_n   <= 62'(SQ_ONE - p_fsq);
    f2_s.f <= f1_f;
    f2_s.b <= f1_bs;
  end

  // bearing angle
  logic        s2_valid;
  logic [30:0] s2_root;
  fs_t         s2_s;

  gcdb_isqrt #(.TW($bits(fs_t))) u_sqrt_bear (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f2_v),
    .in_n      (f2_n),
    .in_side   (f2_s),
    .out_valid (s2_valid),
    .out_root  (s2_root),
    .out_side  (s2_s)
  );

  logic   a2_valid;
  phase_t a2_az, az_m;
  bs_t    a2_bs;
  logic [32:0] az_r;

  gcdb_angle #(.ITER(ANGLE_ITERATIONS), .TW($bits(bs_t))) u_angle_bear (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_x      (s2_s.f),
    .in_y      ($signed({1'b0, s2_root})),
    .in_side   (s2_s.b),
    .out_valid (a2_valid),
    .out_angle (a2_az),
    .out_side  (a2_bs)
  );

  // westward difference mirrors the bearing
  assign az_m = (a2_bs.dl != '0 && a2_bs.dl <= HALF_TURN) ? (32'd0 - a2_az) : a2_az;
  assign az_r = {1'b0, az_m} + 33'd128;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= a2_valid;
    end
    distance   <= a2_bs.gc_dist;
    degenerate <= a2_bs.degen;
    bearing    <= a2_bs.degen ? 24'd0 : az_r[31:8];
  end

endmodule

### hw/rtl/gcdb_phase.sv
// Degrees-to-phase conversion for four coordinates and the longitude difference.
module gcdb_phase
  import gcdb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [29:0] start_lat,
  input  logic signed [30:0] start_lon,
  input  logic signed [29:0] end_lat,
  input  logic signed [30:0] end_lon,
  output logic               out_valid,
  output phase_t             out_lat1,
  output phase_t             out_lat2,
  output phase_t             out_dlon
);

  logic signed [30:0] deg [4];
  logic [31:0] u_c [4];
  logic [31:0] u_r [4];
  logic [64:0] prod [4];
  logic [26:0] kq [4];
  logic [12:0] tt [4];
  phase_t ph [4];
  logic [3:0] vld;

  assign deg[0] = 31'(start_lat);
  assign deg[1] = start_lon;
  assign deg[2] = 31'(end_lat);
  assign deg[3] = end_lon;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      u_c[l] = 32'(deg[l]) + LON_BIAS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], in_valid};
    end
    for (int l = 0; l < 4; l++) begin
      logic [26:0] kc;
      logic [31:0] rm;
      logic [25:0] qp;
      u_r[l] <= u_c[l];
      prod[l] <= u_c[l] * RECIP_45;
      kc = prod[l][64:38];
      rm = u_r[l] - 32'(kc) * 32'd45;
      kq[l] <= kc;
      tt[l] <= {rm[5:0], 7'b0} + 13'd22;
      qp = tt[l] * RECIP_45_S;
      ph[l] <= {kq[l][24:0], 7'b0} + 32'(qp[25:18]);
    end
    out_lat1 <= ph[0];
    out_lat2 <= ph[2];
    out_dlon <= ph[1] - ph[3];
  end

  assign out_valid = vld[3];

endmodule

### hw/rtl/gcdb_sincos.sv
// Pipelined rotation CORDIC giving cosine and sine of three phases in parallel lanes.
module gcdb_sincos
  import gcdb_pkg::*;
#(
  parameter int unsigned ITER = ANGLE_ITERATIONS_DEF,
  parameter int unsigned TW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  phase_t        in_phase [SC_LANES],
  input  logic [TW-1:0] in_side,
  output logic          out_valid,
  output q30_t          out_cos [SC_LANES],
  output q30_t          out_sin [SC_LANES],
  output logic [TW-1:0] out_side
);

  cw_t xs [ITER+1][SC_LANES];
  cw_t ys [ITER+1][SC_LANES];
  cw_t zs [ITER+1][SC_LANES];
  logic ng [ITER+1][SC_LANES];
  logic [TW-1:0] sd [ITER+1];
  logic [ITER+1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[ITER:0], in_valid};
    end
    sd[0] <= in_side;
    for (int l = 0; l < SC_LANES; l++) begin
      cw_t zi;
      zi = 34'($signed(in_phase[l]));
      xs[0][l] <= KINV_Q30;
      ys[0][l] <= '0;
      if (zi > ONE_Q30) begin
        zs[0][l] <= zi - HALF_S;
        ng[0][l] <= 1'b1;
      end else if (zi < -ONE_Q30) begin
        zs[0][l] <= zi + HALF_S;
        ng[0][l] <= 1'b1;
      end else begin
        zs[0][l] <= zi;
        ng[0][l] <= 1'b0;
      end
    end
    for (int k = 0; k < ITER; k++) begin
      sd[k+1] <= sd[k];
      for (int l = 0; l < SC_LANES; l++) begin
        ng[k+1][l] <= ng[k][l];
        if (zs[k][l] >= 0) begin
          xs[k+1][l] <= xs[k][l] - (ys[k][l] >>> k);
          ys[k+1][l] <= ys[k][l] + (xs[k][l] >>> k);
          zs[k+1][l] <= zs[k][l] - 34'(atan_phase(k));
        end else begin
          xs[k+1][l] <= xs[k][l] + (ys[k][l] >>> k);
          ys[k+1][l] <= ys[k][l] - (xs[k][l] >>> k);
          zs[k+1][l] <= zs[k][l] + 34'(atan_phase(k));
        end
      end
    end
    for (int l = 0; l < SC_LANES; l++) begin
      out_cos[l] <= clamp_q30(ng[ITER][l] ? -xs[ITER][l] : xs[ITER][l]);
      out_sin[l] <= clamp_q30(ng[ITER][l] ? -ys[ITER][l] : ys[ITER][l]);
    end
    out_side <= sd[ITER];
  end

  assign out_valid = vld[ITER+1];

endmodule

### hw/rtl/gcdb_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module gcdb_isqrt
  import gcdb_pkg::*;
#(
  parameter int unsigned TW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [61:0]   in_n,
  input  logic [TW-1:0] in_side,
  output logic          out_valid,
  output logic [30:0]   out_root,
  output logic [TW-1:0] out_side
);

  sq_t sq [SQRT_STEPS];
  logic [61:0] nn [SQRT_STEPS];
  logic [TW-1:0] sd [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[SQRT_STEPS-2:0], in_valid};
    end
    sq[0] <= sqrt_step('0, in_n[61:60]);
    nn[0] <= {in_n[59:0], 2'b00};
    sd[0] <= in_side;
    for (int s = 1; s < SQRT_STEPS; s++) begin
      sq[s] <= sqrt_step(sq[s-1], nn[s-1][61:60]);
      nn[s] <= {nn[s-1][59:0], 2'b00};
      sd[s] <= sd[s-1];
    end
  end

  assign out_valid = vld[SQRT_STEPS-1];
  assign out_root = sq[SQRT_STEPS-1].root;
  assign out_side = sd[SQRT_STEPS-1];

endmodule

### hw/rtl/gcdb_angle.sv
// Pipelined vectoring CORDIC: angle of (x, y) as a phase clamped to [0, half turn].
module gcdb_angle
  import gcdb_pkg::*;
#(
  parameter int unsigned ITER = ANGLE_ITERATIONS_DEF,
  parameter int unsigned TW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  q30_t          in_x,
  input  q30_t          in_y,
  input  logic [TW-1:0] in_side,
  output logic          out_valid,
  output phase_t        out_angle,
  output logic [TW-1:0] out_side
);

  cw_t xs [ITER+1];
  cw_t ys [ITER+1];
  cw_t zs [ITER+1];
  logic [TW-1:0] sd [ITER+1];
  logic [ITER+1:0] vld;
  cw_t xi;
  cw_t yi;

  assign xi = 34'(in_x);
  assign yi = 34'(in_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[ITER:0], in_valid};
    end
    sd[0] <= in_side;
    if (xi < 0) begin
      xs[0] <= -xi;
      ys[0] <= -yi;
      zs[0] <= HALF_S;
    end else begin
      xs[0] <= xi;
      ys[0] <= yi;
      zs[0] <= '0;
    end
    for (int k = 0; k < ITER; k++) begin
      sd[k+1] <= sd[k];
      if (ys[k] > 0) begin
        xs[k+1] <= xs[k] + (ys[k] >>> k);
        ys[k+1] <= ys[k] - (xs[k] >>> k);
        zs[k+1] <= zs[k] + 34'(atan_phase(k));
      end else begin
        xs[k+1] <= xs[k] - (ys[k] >>> k);
        ys[k+1] <= ys[k] + (xs[k] >>> k);
        zs[k+1] <= zs[k] - 34'(atan_phase(k));
      end
    end
    if (zs[ITER] < 0) begin
      out_angle <= '0;
    end else if (zs[ITER] > HALF_S) begin
      out_angle <= HALF_TURN;
    end else begin
      out_angle <= zs[ITER][31:0];
    end
    out_side <= sd[ITER];
  end

  assign out_valid = vld[ITER+1];

endmodule

### hw/rtl/gcdb_div.sv
// Pipelined restoring divider: floor(num * 2^30 / den) for num below den.
module gcdb_div
  import gcdb_pkg::*;
#(
  parameter int unsigned TW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [30:0]   in_num,
  input  logic [30:0]   in_den,
  input  logic [TW-1:0] in_side,
  output logic          out_valid,
  output logic [29:0]   out_quo,
  output logic [TW-1:0] out_side
);

  dv_t dv [DIV_STEPS];
  logic [30:0] dd [DIV_STEPS];
  logic [TW-1:0] sd [DIV_STEPS];
  logic [DIV_STEPS-1:0] vld;
  dv_t dv_in;

  assign dv_in.rem = {1'b0, in_num};
  assign dv_in.quo = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DIV_STEPS-2:0], in_valid};
    end
    dv[0] <= div_step(dv_in, in_den);
    dd[0] <= in_den;
    sd[0] <= in_side;
    for (int s = 1; s < DIV_STEPS; s++) begin
      dv[s] <= div_step(dv[s-1], dd[s-1]);
      dd[s] <= dd[s-1];
      sd[s] <= sd[s-1];
    end
  end

  assign out_valid = vld[DIV_STEPS-1];
  assign out_quo = dv[DIV_STEPS-1].quo;
  assign out_side = sd[DIV_STEPS-1];

endmodule

### hw/rtl/gcdb_checker.sv
// Port-level assertions for the great circle distance and bearing block, with bind.
module gcdb_checker
  import gcdb_pkg::*;
#(
  parameter int unsigned ITER = ANGLE_ITERATIONS_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [23:0] bearing,
  input logic        degenerate
);

  localparam int unsigned LAT = pipe_latency(ITER);

  a_never_busy : assert property (@(posedge clk) !busy)
    else $error("busy raised");

  a_done_has_request : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without matching request");

  a_degen_bearing : assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (bearing == 24'd0))
    else $error("degenerate result with nonzero bearing");

  a_reset_quiet : assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("done right after reset");

endmodule

bind great_circle_distance_bearing gcdb_checker #(.ITER(ANGLE_ITERATIONS)) u_gcdb_checker (.*);
